### hdl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Types, character codes and helpers shared by the decimal comma detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

  typedef enum logic [1:0] {
    PhStart   = 2'd0,
    PhComment = 2'd1,
    PhToken   = 2'd2,
    PhGap     = 2'd3
  } phase_e;

  localparam logic [7:0] CharNul   = 8'd0;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharHash  = 8'd35;
  localparam logic [7:0] CharComma = 8'd44;
  localparam logic [7:0] CharDot   = 8'd46;

  localparam logic [1:0] CountOne = 2'd1;
  localparam logic [1:0] CountTwo = 2'd2;
  localparam logic [1:0] CountMax = 2'd3;

  typedef struct packed {
    logic is_comma_decimal;
    logic saw_vote_for;
    logic saw_vote_against;
  } verdict_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharCr);
  endfunction

  function automatic logic [1:0] sat_inc(input logic [1:0] v);
    return (v == CountMax) ? CountMax : v + 2'd1;
  endfunction

endpackage

### hdl/dcd_line_fsm.sv
// ----------------------------------------------------------------------------
// dcd_line_fsm
// Per-byte line and token tracker that collects the votes of one text.
// ----------------------------------------------------------------------------
module dcd_line_fsm import dcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output verdict_t   verdict_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] token_commas_q, token_commas_d;
  logic       token_has_dot_q, token_has_dot_d;
  logic [1:0] line_tokens_q, line_tokens_d;
  logic [1:0] one_comma_q, one_comma_d;
  logic       line_has_dot_q, line_has_dot_d;
  logic       line_multi_q, line_multi_d;
  logic       vote_for_q, vote_for_d;
  logic       vote_against_q, vote_against_d;

  logic       is_nul, is_lf, blank, is_comma, is_dot, is_hash;
  logic [1:0] ct_tokens, ct_one, eol_tokens, eol_one;
  logic       ct_multi, ct_dot, eol_multi, eol_dot;
  logic       judge, line_for, line_against, for_next, against_next;
  logic [1:0] cnt_commas;
  logic       cnt_dot;

  assign is_nul   = (byte_i == CharNul);
  assign is_lf    = (byte_i == CharLf);
  assign is_hash  = (byte_i == CharHash);
  assign is_comma = (byte_i == CharComma);
  assign is_dot   = (byte_i == CharDot);
  assign blank    = is_blank(byte_i);

  // Line totals as they stand once the current token is closed.
  assign ct_tokens = sat_inc(line_tokens_q);
  assign ct_one    = (token_commas_q == CountOne) ? sat_inc(one_comma_q) : one_comma_q;
  assign ct_multi  = line_multi_q | (token_commas_q >= CountTwo);
  assign ct_dot    = line_has_dot_q | token_has_dot_q;

  assign eol_tokens = (phase_q == PhToken) ? ct_tokens : line_tokens_q;
  assign eol_one    = (phase_q == PhToken) ? ct_one : one_comma_q;
  assign eol_multi  = (phase_q == PhToken) ? ct_multi : line_multi_q;
  assign eol_dot    = (phase_q == PhToken) ? ct_dot : line_has_dot_q;

  assign judge    = (phase_q == PhToken) || (phase_q == PhGap);
  assign line_for = judge && (eol_tokens == CountTwo) && (eol_one == CountTwo) &&
                    !eol_dot && !eol_multi;
  assign line_against = judge && !line_for &&
                        (eol_dot || eol_multi || (eol_tokens != CountTwo));
  assign for_next     = vote_for_q | line_for;
  assign against_next = vote_against_q | line_against;

  assign cnt_commas = is_comma ? sat_inc(token_commas_q) : token_commas_q;
  assign cnt_dot    = token_has_dot_q | is_dot;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_nul || is_lf) begin
      phase_d = PhStart;
    end else begin
      case (phase_q)
        PhStart: begin
          if (!blank) phase_d = is_hash ? PhComment : PhToken;
        end
        PhComment: phase_d = PhComment;
        PhToken: begin
          if (blank) phase_d = PhGap;
        end
        PhGap: begin
          if (!blank) phase_d = PhToken;
        end
        default: phase_d = PhStart;
      endcase
    end
  end

  // Counters and sticky votes.
  always_comb begin
    token_commas_d  = token_commas_q;
    token_has_dot_d = token_has_dot_q;
    line_tokens_d   = line_tokens_q;
    one_comma_d     = one_comma_q;
    line_has_dot_d  = line_has_dot_q;
    line_multi_d    = line_multi_q;
    vote_for_d      = vote_for_q;
    vote_against_d  = vote_against_q;
    if (is_nul || is_lf) begin
      token_commas_d  = '0;
      token_has_dot_d = 1'b0;
      line_tokens_d   = '0;
      one_comma_d     = '0;
      line_has_dot_d  = 1'b0;
      line_multi_d    = 1'b0;
      vote_for_d      = is_nul ? 1'b0 : for_next;
      vote_against_d  = is_nul ? 1'b0 : against_next;
    end else begin
      case (phase_q)
        PhStart: begin
          if (!blank && !is_hash) begin
            token_commas_d  = cnt_commas;
            token_has_dot_d = cnt_dot;
          end
        end
        PhComment: ;
        PhToken: begin
          if (blank) begin
            line_tokens_d   = ct_tokens;
            one_comma_d     = ct_one;
            line_multi_d    = ct_multi;
            line_has_dot_d  = ct_dot;
            token_commas_d  = '0;
            token_has_dot_d = 1'b0;
          end else begin
            token_commas_d  = cnt_commas;
            token_has_dot_d = cnt_dot;
          end
        end
        PhGap: begin
          if (!blank) begin
            token_commas_d  = cnt_commas;
            token_has_dot_d = cnt_dot;
          end
        end
        default: ;
      endcase
    end
  end

  // Verdict of the text, meaningful when the byte is the terminator.
  always_comb begin
    verdict_o.is_comma_decimal = for_next && !against_next;
    verdict_o.saw_vote_for     = for_next;
    verdict_o.saw_vote_against = against_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PhStart;
      token_commas_q  <= '0;
      token_has_dot_q <= 1'b0;
      line_tokens_q   <= '0;
      one_comma_q     <= '0;
      line_has_dot_q  <= 1'b0;
      line_multi_q    <= 1'b0;
      vote_for_q      <= 1'b0;
      vote_against_q  <= 1'b0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      token_commas_q  <= token_commas_d;
      token_has_dot_q <= token_has_dot_d;
      line_tokens_q   <= line_tokens_d;
      one_comma_q     <= one_comma_d;
      line_has_dot_q  <= line_has_dot_d;
      line_multi_q    <= line_multi_d;
      vote_for_q      <= vote_for_d;
      vote_against_q  <= vote_against_d;
    end
  end

endmodule

### hdl/decimal_comma_detector.sv
// Path: an accepted byte is held in the input register and from there updates
// the line state; a terminator's verdict is loaded into the result register.
// Throughput: one byte per cycle while in_stall_o is low; the single input
// register feeds the per-byte state update and the result register.
// Reset: rst_ni clears all line, token and vote state and both valid flags at once.
// ----------------------------------------------------------------------------
// decimal_comma_detector
// Decides per text whether numbers are written with a decimal comma.
// ----------------------------------------------------------------------------
module decimal_comma_detector import dcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_comma_decimal_o,
  output logic       saw_vote_for_o,
  output logic       saw_vote_against_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] byte_q;
  logic       s1_fire, in_fire, out_load;
  logic       out_valid_q, out_valid_d;
  verdict_t   verdict, result_q;

  // The byte in the input register moves on unless it is a terminator and the
  // result register still holds a beat that is stalled.
  assign s1_fire  = s1_valid_q && !((byte_q == CharNul) && out_valid_q && out_stall_i);
  assign out_load = s1_fire && (byte_q == CharNul);

  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire | (s1_valid_q & !s1_fire);

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  dcd_line_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .byte_i    (byte_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) byte_q <= char_byte_i;
    if (out_load) result_q <= verdict;
  end

  assign out_valid_o        = out_valid_q;
  assign is_comma_decimal_o = result_q.is_comma_decimal;
  assign saw_vote_for_o     = result_q.saw_vote_for;
  assign saw_vote_against_o = result_q.saw_vote_against;

`ifndef SYNTHESIS
  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_comma_decimal_o == (saw_vote_for_o && !saw_vote_against_o)))
    else $error("verdict does not match the vote flags");

  a_result_from_terminator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && (byte_q == CharNul)))
    else $error("result beat without a terminator");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");
`endif

endmodule
